// ----- sv/total_correlation_estimator_unit_macros.svh -----
// Assertion macros for the total correlation estimator
`ifndef TOTAL_CORRELATION_ESTIMATOR_UNIT_MACROS_SVH
`define TOTAL_CORRELATION_ESTIMATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TCE_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: check failed");
// Next-cycle implication.
`define TCE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: check failed");
`endif

// ----- sv/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and state codes for the total correlation estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tce_pkg;
    localparam int VAL_BITS  = 3;
    localparam int INFO_BITS = 20;
    localparam int ROW_BITS  = 16;
    localparam int VC_BITS   = 3;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_NLOG  = 3'd5;

    typedef struct packed {
        logic [VAL_BITS-1:0] value_0;
        logic [VAL_BITS-1:0] value_1;
        logic [VAL_BITS-1:0] value_2;
        logic [VAL_BITS-1:0] value_3;
        logic                last_row;
    } row_t;

    typedef struct packed {
        logic [INFO_BITS-1:0] info_q16;
        logic [ROW_BITS-1:0]  row_count;
        logic                 overflow;
    } result_t;
endpackage

// ----- sv/tce_if.sv -----
// ----------------------------------------------------------------------------
// tce_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tce_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tce_ram.sv -----
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/tce_log2.sv -----
// ----------------------------------------------------------------------------
// tce_log2
// Iterative fixed-point log2 by repeated squaring, one fraction bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tce_log2
    import tce_pkg::*;
#(
    parameter int COUNT_BITS    = 16,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] x,
    output logic                  busy,
    output logic [$clog2(COUNT_BITS)+LOG_FRAC_BITS-1:0] result
);
    localparam int EB = $clog2(COUNT_BITS);
    localparam int CB = $clog2(LOG_FRAC_BITS + 1);

    logic [31:0]   y_reg, y_next;
    logic [EB-1:0] e_reg, e_next;
    logic [LOG_FRAC_BITS-1:0] f_reg, f_next;
    logic [CB-1:0] n_reg, n_next;
    logic          busy_reg, busy_next;
    logic [63:0]   sq;
    logic [EB-1:0] top;

    // leading one position
    always_comb
    begin
        top = '0;
        for (int i = 0; i < COUNT_BITS; i++)
        begin
            if (x[i])
            begin
                top = EB'(i);
            end
        end
    end

    assign sq = (64'(y_reg) * 64'(y_reg)) >> 30;

    always_comb
    begin
        y_next    = y_reg;
        e_next    = e_reg;
        f_next    = f_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        if (start)
        begin
            e_next    = top;
            y_next    = 32'((64'(x) << 30) >> top);
            f_next    = '0;
            n_next    = '0;
            busy_next = (x != '0);
        end
        else if (busy_reg)
        begin
            if (sq >= 64'h8000_0000)
            begin
                y_next = 32'(sq >> 1);
                f_next = {f_reg[LOG_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                y_next = sq[31:0];
                f_next = {f_reg[LOG_FRAC_BITS-2:0], 1'b0};
            end
            n_next = n_reg + 1'b1;
            if (n_reg == CB'(LOG_FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        e_reg <= e_next;
        f_reg <= f_next;
    end

    assign busy   = busy_reg;
    assign result = {e_reg, f_reg};
endmodule

// ----- sv/tce_divider.sv -----
// ----------------------------------------------------------------------------
// tce_divider
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tce_divider
    import tce_pkg::*;
#(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CB = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg;
    logic [CB-1:0]       n_reg, n_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   trial;

    assign trial = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            n_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            n_next = n_reg + 1'b1;
            if (n_reg == CB'(NUM_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

// ----- sv/total_correlation_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// total_correlation_estimator_unit
// Plug-in total correlation over streamed rows of categorical symbols.
// ----------------------------------------------------------------------------
// channel    dir  payload                              handshake
// in_row     in   value_0..3, last_row                 valid/ready
// result     out  info_q16, row_count, overflow        valid/ready
// cfg        in   var_count                            valid/ready
//
// An ordinary row is handled as a joint RAM read, then an add and write back.
// A last row then computes log2 N and walks all joint cells; each nonzero
// cell runs five log lanes in parallel, and a divide follows the walk.
// After reset a clearing pass sweeps the joint RAM before the first row
// is taken. A stalled result holds the block; the next set then starts
// after the sweep that follows delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module total_correlation_estimator_unit
    import tce_pkg::*;
#(
    parameter int MAX_VARS      = 4,
    parameter int SYMBOL_BITS   = 3,
    parameter int COUNT_BITS    = 16,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    tce_stream_if.sink   in_row,
    tce_stream_if.source result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [VC_BITS-1:0] cfg_data
);
    localparam int JA      = MAX_VARS * SYMBOL_BITS;
    localparam int JDEPTH  = 1 << JA;
    localparam int MDEPTH  = MAX_VARS << SYMBOL_BITS;
    localparam int MB      = $clog2(MDEPTH);
    localparam int LB      = $clog2(COUNT_BITS) + LOG_FRAC_BITS;
    localparam int ACC     = 48;
    localparam int VB      = $clog2(MAX_VARS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [INFO_BITS-1:0]  IMAX =
        INFO_BITS'(((MAX_VARS - 1) * SYMBOL_BITS) << 16);
    localparam int NLANE   = MAX_VARS + 1;

    // row update phases
    localparam logic [1:0] PH_RD = 2'd0;
    localparam logic [1:0] PH_WR = 2'd1;
    // walk sub-phases
    localparam logic [1:0] PH_ISSUE = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_ADD   = 2'd3;

    logic [2:0]  st_reg, st_next;
    logic [VC_BITS-1:0] vc_reg;
    logic [JA:0] addr_reg;       // sweep address, one spare bit for end
    logic [1:0]  ph_reg;         // row update phase / walk sub-phase
    logic [COUNT_BITS-1:0] marg_reg [MDEPTH];
    logic [COUNT_BITS-1:0] rows_reg;
    logic        ovf_reg;
    logic signed [ACC-1:0] acc_reg;
    logic        lastrow_reg;
    logic [JA-1:0] cell_reg;
    logic [COUNT_BITS-1:0] c_reg;
    logic [LB-1:0] logn_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    row_t        row;

    // ram
    logic                  we;
    logic [JA-1:0]         waddr, raddr;
    logic [COUNT_BITS-1:0] wdata, rdata;

    // lanes: lane 0 gets the cell count, lanes 1.. the marginals
    logic                  lane_start [NLANE];
    logic                  lane_busy  [NLANE];
    logic [COUNT_BITS-1:0] lane_x     [NLANE];
    logic [LB-1:0]         lane_q     [NLANE];
    logic                  any_busy;

    logic                  div_start, div_busy;
    logic [ACC-1:0]        quot;

    logic [VB-1:0]         k;

    assign row = in_row.data;

    always_comb
    begin
        if (vc_reg == '0)
        begin
            k = VB'(1);
        end
        else if (vc_reg > VC_BITS'(MAX_VARS))
        begin
            k = VB'(MAX_VARS);
        end
        else
        begin
            k = VB'(vc_reg);
        end
    end

    function automatic logic [SYMBOL_BITS-1:0] sym_of(input row_t r, input int j);
        logic [VAL_BITS-1:0] v;
        v = (j == 0) ? r.value_0 : (j == 1) ? r.value_1 :
            (j == 2) ? r.value_2 : r.value_3;
        return SYMBOL_BITS'(v);
    endfunction

    // marginal slot of symbol s of variable j
    function automatic logic [MB-1:0] marg_idx(input int j,
                                               input logic [SYMBOL_BITS-1:0] s);
        return MB'(j << SYMBOL_BITS) | MB'(s);
    endfunction

    // joint cell index of the incoming row
    logic [JA-1:0] row_cell;
    always_comb
    begin
        row_cell = '0;
        for (int j = 0; j < MAX_VARS; j++)
        begin
            if (VB'(j) < k)
            begin
                row_cell[j*SYMBOL_BITS +: SYMBOL_BITS] = sym_of(row, j);
            end
        end
    end

    // marginal slots of the incoming row, and whether the row counter or a marginal counter in use is full
    logic [MB-1:0] row_midx [MAX_VARS];
    logic          row_sat;
    always_comb
    begin
        row_sat = (rows_reg == CMAX);
        for (int j = 0; j < MAX_VARS; j++)
        begin
            row_midx[j] = marg_idx(j, sym_of(row, j));
            if (VB'(j) < k && marg_reg[row_midx[j]] == CMAX)
            begin
                row_sat = 1'b1;
            end
        end
    end

    tce_ram #(.WIDTH(COUNT_BITS), .DEPTH(JDEPTH)) u_joint (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    genvar g;
    generate
        for (g = 0; g < NLANE; g++)
        begin : g_lane
            tce_log2 #(.COUNT_BITS(COUNT_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
                .clk(clk), .rst_n(rst_n), .start(lane_start[g]),
                .x(lane_x[g]), .busy(lane_busy[g]), .result(lane_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < NLANE; i++)
        begin
            any_busy = any_busy | lane_busy[i];
        end
    end

    // lane operands: lane 0 takes N on the last row and the cell count in
    // WALK; lane j+1 takes m_j of the cell being read
    logic lanes_go;
    always_comb
    begin
        lane_x[0] = (st_reg == ST_WALK) ? rdata : rows_reg;
        for (int j = 0; j < MAX_VARS; j++)
        begin
            lane_x[j+1] = marg_reg[marg_idx(j, addr_reg[j*SYMBOL_BITS +: SYMBOL_BITS])];
        end
        for (int i = 0; i < NLANE; i++)
        begin
            lane_start[i] = lanes_go && (i == 0 || st_reg == ST_WALK);
        end
    end

    tce_divider #(.NUM_BITS(ACC), .DEN_BITS(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_reg),
        .den(rows_reg), .busy(div_busy), .quot(quot)
    );

    // merge: d = L(c) + (k-1)L(N) - sum L(m_j)
    logic [LB+VB-1:0]      logn_k;
    logic signed [ACC-1:0] d_sum;
    always_comb
    begin
        logn_k = (LB+VB)'(logn_reg) * (LB+VB)'(k - 1'b1);
        d_sum  = ACC'(lane_q[0]) + ACC'(logn_k);
        for (int j = 0; j < MAX_VARS; j++)
        begin
            if (VB'(j) < k)
            begin
                d_sum = d_sum - ACC'(lane_q[j+1]);
            end
        end
    end

    logic signed [ACC-1:0] prod_reg;
    logic [ACC-1:0] q_adj;
    always_comb
    begin
        if (LOG_FRAC_BITS >= 16)
        begin
            q_adj = quot >> (LOG_FRAC_BITS - 16);
        end
        else
        begin
            q_adj = quot << (16 - LOG_FRAC_BITS);
        end
    end

    assign in_row.ready = (st_reg == ST_IDLE) && (ph_reg == PH_RD) && !res_valid_reg;
    assign cfg_ready    = 1'b1;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // control flow
    logic acc_row;
    assign acc_row = in_row.valid && in_row.ready;

    always_comb
    begin
        we        = 1'b0;
        waddr     = cell_reg;
        wdata     = '0;
        raddr     = row_cell;
        lanes_go  = 1'b0;
        div_start = 1'b0;
        st_next   = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = addr_reg[JA-1:0];
                if (addr_reg == (JA+1)'(JDEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ph_reg == PH_WR)
                begin
                    we    = 1'b1;
                    wdata = (rdata == CMAX) ? CMAX : rdata + 1'b1;
                    if (lastrow_reg)
                    begin
                        st_next  = ST_NLOG;
                        lanes_go = 1'b1;
                    end
                end
            end
            ST_NLOG:
            begin
                raddr = '0;
                if (!any_busy && !lanes_go)
                begin
                    st_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                raddr = addr_reg[JA-1:0];
                if (ph_reg == PH_DATA && rdata != '0)
                begin
                    lanes_go = 1'b1;
                end
                if (addr_reg[JA] && ph_reg == PH_ISSUE)
                begin
                    st_next   = ST_DIV;
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (!div_busy && !div_start)
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg)
                begin
                    st_next = ST_CLEAR;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    // walk sub-phases: issue read, data back (launch lanes), wait, add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            vc_reg        <= VC_BITS'(2);
            addr_reg      <= '0;
            ph_reg        <= PH_RD;
            res_valid_reg <= 1'b0;
            lastrow_reg   <= 1'b0;
            rows_reg      <= '0;
            ovf_reg       <= 1'b0;
            acc_reg       <= '0;
            cell_reg      <= '0;
            c_reg         <= '0;
            logn_reg      <= '0;
            prod_reg      <= '0;
            for (int i = 0; i < MDEPTH; i++)
            begin
                marg_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready)
            begin
                vc_reg <= cfg_data;
            end
            if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_CLEAR:
                begin
                    addr_reg <= (st_next == ST_IDLE) ? '0 : addr_reg + 1'b1;
                    ph_reg   <= PH_RD;
                    rows_reg <= '0;
                    ovf_reg  <= 1'b0;
                    acc_reg  <= '0;
                    for (int i = 0; i < MDEPTH; i++)
                    begin
                        marg_reg[i] <= '0;
                    end
                end
                ST_IDLE:
                begin
                    if (acc_row)
                    begin
                        ph_reg      <= PH_WR;
                        lastrow_reg <= row.last_row;
                        cell_reg    <= row_cell;
                        rows_reg    <= (rows_reg == CMAX) ? CMAX : rows_reg + 1'b1;
                        if (row_sat)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        // advance each marginal in use, hold it once full
                        for (int j = 0; j < MAX_VARS; j++)
                        begin
                            if (VB'(j) < k && marg_reg[row_midx[j]] != CMAX)
                            begin
                                marg_reg[row_midx[j]] <= marg_reg[row_midx[j]] + 1'b1;
                            end
                        end
                    end
                    else if (ph_reg == PH_WR)
                    begin
                        ph_reg <= PH_RD;
                        if (rdata == CMAX)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        addr_reg <= '0;
                    end
                end
                ST_NLOG:
                begin
                    logn_reg <= lane_q[0];
                    ph_reg   <= PH_ISSUE;
                    addr_reg <= '0;
                end
                ST_WALK:
                begin
                    case (ph_reg)
                        PH_ISSUE:
                        begin
                            ph_reg <= PH_DATA;
                        end
                        PH_DATA:
                        begin
                            cell_reg <= addr_reg[JA-1:0];
                            c_reg    <= rdata;
                            if (rdata == '0)
                            begin
                                ph_reg   <= PH_ISSUE;
                                addr_reg <= addr_reg + 1'b1;
                            end
                            else
                            begin
                                ph_reg <= PH_WAIT;
                            end
                        end
                        PH_WAIT:
                        begin
                            if (!any_busy)
                            begin
                                prod_reg <= d_sum;
                                ph_reg   <= PH_ADD;
                            end
                        end
                        default:
                        begin
                            acc_reg  <= acc_reg + prod_reg * $signed({1'b0, c_reg});
                            ph_reg   <= PH_ISSUE;
                            addr_reg <= addr_reg + 1'b1;
                        end
                    endcase
                end
                ST_DIV:
                begin
                    if (st_next == ST_OUT)
                    begin
                        res_valid_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    addr_reg <= '0;
                end
                default:
                begin
                    addr_reg <= '0;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_DIV && st_next == ST_OUT)
        begin
            res_reg.row_count <= ROW_BITS'(rows_reg);
            res_reg.overflow  <= ovf_reg;
            if (acc_reg <= 0)
            begin
                res_reg.info_q16 <= '0;
            end
            else if (q_adj > ACC'(IMAX))
            begin
                res_reg.info_q16 <= IMAX;
            end
            else
            begin
                res_reg.info_q16 <= q_adj[INFO_BITS-1:0];
            end
        end
    end
endmodule

// ----- sv/tce_checker.sv -----
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks for the total correlation estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "total_correlation_estimator_unit_macros.svh"
module tce_checker
    import tce_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    `TCE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `TCE_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
    `TCE_ASSERT_IMP(a_count_nonzero, clk, rst_n, out_valid, out_data.row_count != '0)
    `TCE_ASSERT_IMP(a_ovf, clk, rst_n, out_valid && out_data.overflow, out_data.row_count == '1)
    `TCE_ASSERT_NEXT(a_ready_drop, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind total_correlation_estimator_unit tce_checker u_tce_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_row.valid), .in_ready(in_row.ready),
    .out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
);

// ----- dv/tce_tc_monitor.sv -----
// ----------------------------------------------------------------------------
// tce_tc_monitor
// Watches the row, result and config channels of the total correlation
// estimator, predicts each data set's result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tce_tc_monitor
    import tce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               row_valid,
    input  logic               row_ready,
    input  row_t               row_data,
    input  logic               res_valid,
    input  logic               res_ready,
    input  result_t            res_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [VC_BITS-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);
    localparam int          NVARS    = 4;
    localparam int          SBITS    = 3;
    localparam int unsigned CNT_TOP  = 65535;
    localparam longint      INFO_CAP = 589824;

    int unsigned      joint_hist [4096];
    int unsigned      marg_hist [32];
    int unsigned      rows_in_set;
    bit               set_ovf;
    logic [VC_BITS-1:0] var_count_q;
    result_t          expected_info [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // log2 in Q16 by repeated squaring of a Q30 mantissa
    function automatic longint log2_q16(input int unsigned x);
        int unsigned       e;
        int unsigned       t;
        int unsigned       frac;
        longint unsigned   y;
        if (x == 0)
            return 0;
        e = 0;
        t = x;
        frac = 0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        y = longint'(x) << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        return longint'((e << 16) | frac);
    endfunction

    function automatic int unsigned sat_inc(input int unsigned v);
        if (v >= CNT_TOP)
        begin
            set_ovf = 1'b1;
            return CNT_TOP;
        end
        return v + 1;
    endfunction

    function automatic int unsigned active_vars();
        if (var_count_q == 0)
            return 1;
        if (var_count_q > NVARS)
            return NVARS;
        return var_count_q;
    endfunction

    task automatic clear_set();
        foreach (joint_hist[i]) joint_hist[i] = 0;
        foreach (marg_hist[i]) marg_hist[i] = 0;
        rows_in_set = 0;
        set_ovf = 1'b0;
    endtask

    // count one row; on the last row of a set, walk the joint histogram
    task automatic absorb_row(input row_t r);
        int unsigned k;
        int unsigned joint_idx;
        int unsigned sym;
        int unsigned syms [4];
        longint      logn;
        longint      acc;
        longint      d;
        longint      q;
        result_t     res;
        k = active_vars();
        syms[0] = r.value_0;
        syms[1] = r.value_1;
        syms[2] = r.value_2;
        syms[3] = r.value_3;
        joint_idx = 0;
        for (int j = 0; j < k; j++)
        begin
            joint_idx |= syms[j] << (j * SBITS);
            marg_hist[(j << SBITS) | syms[j]] = sat_inc(marg_hist[(j << SBITS) | syms[j]]);
        end
        joint_hist[joint_idx] = sat_inc(joint_hist[joint_idx]);
        rows_in_set = sat_inc(rows_in_set);
        if (!r.last_row)
            return;
        logn = log2_q16(rows_in_set);
        acc = 0;
        for (int idx = 0; idx < 4096; idx++)
        begin
            if (joint_hist[idx] == 0)
                continue;
            d = log2_q16(joint_hist[idx]) + longint'(k - 1) * logn;
            for (int j = 0; j < k; j++)
            begin
                sym = (idx >> (j * SBITS)) & 7;
                d -= log2_q16(marg_hist[(j << SBITS) | sym]);
            end
            acc += longint'(joint_hist[idx]) * d;
        end
        if (acc <= 0 || rows_in_set == 0)
            q = 0;
        else
        begin
            q = acc / longint'(rows_in_set);
            if (q > INFO_CAP)
                q = INFO_CAP;
        end
        res.info_q16  = q[INFO_BITS-1:0];
        res.row_count = rows_in_set[ROW_BITS-1:0];
        res.overflow  = set_ovf;
        expected_info = {expected_info, res};
        clear_set();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set();
            var_count_q = 3'd2;
            expected_info.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                var_count_q = cfg_data;
            if (row_valid && row_ready)
                absorb_row(row_data);
            if (res_valid && res_ready)
            begin
                if (expected_info.size() == 0)
                begin
                    report("unexpected result", 1, 0);
                end
                else
                begin
                    result_t want;
                    want = expected_info.pop_front();
                    if (res_data.info_q16 !== want.info_q16)
                        report("info_q16", res_data.info_q16, want.info_q16);
                    if (res_data.row_count !== want.row_count)
                        report("row_count", res_data.row_count, want.row_count);
                    if (res_data.overflow !== want.overflow)
                        report("overflow", res_data.overflow, want.overflow);
                end
            end
        end
        pending = expected_info.size();
    end
endmodule

// ----- dv/total_correlation_estimator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// total_correlation_estimator_unit_tb
// Streams data sets of symbol rows into the estimator under random idling
// on both sides, sweeps the variable counts 0 to 5 and 7, and lets the monitor check
// each total correlation result against its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module total_correlation_estimator_unit_tb
    import tce_pkg::*;
();

    localparam int RANDOM_ROWS = 1850;
    localparam int SETTLE      = 4600;     // clearing sweep after a result plus margin
    localparam int CYCLE_LIMIT = 8000000;

    logic clk;
    logic rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [VC_BITS-1:0] cfg_data;

    int  fail_count;
    int  pending;
    bit  idle_en;          // random gaps on both sides when set
    int  hold_request;     // cycles of result back-pressure asked for
    int  rows_sent;
    int  cycles;

    tce_stream_if #(.T(row_t))    row_ch ();
    tce_stream_if #(.T(result_t)) res_ch ();

    total_correlation_estimator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_row    (row_ch.sink),
        .result    (res_ch.source),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tce_tc_monitor mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_valid  (row_ch.valid),
        .row_ready  (row_ch.ready),
        .row_data   (row_ch.data),
        .res_valid  (res_ch.valid),
        .res_ready  (res_ch.ready),
        .res_data   (res_ch.data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: give up on a hung block.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("total_correlation_estimator_unit_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off counted down here
    // whenever the stimulus asks for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !(idle_en && $urandom_range(99) < 26);
        end
    end

    // Offer one row and hold it until taken. Valid stays high on return, so
    // back-to-back rows never lower and raise it in the same step.
    task automatic send_row(input row_t r);
        if (idle_en && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        row_ch.valid <= 1'b1;
        row_ch.data  <= r;
        @(posedge clk);
        while (!row_ch.ready)
            @(posedge clk);
        rows_sent++;
    endtask

    task automatic drop_row_valid();
        @(negedge clk);
        row_ch.valid <= 1'b0;
    endtask

    // Drain all results, let the clearing sweep finish, then write var_count.
    task automatic set_var_count(input logic [VC_BITS-1:0] v);
        drop_row_valid();
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t make_row(input int unsigned a, input int unsigned b,
                                      input int unsigned c, input int unsigned d,
                                      input bit last);
        row_t r;
        r.value_0  = a[2:0];
        r.value_1  = b[2:0];
        r.value_2  = c[2:0];
        r.value_3  = d[2:0];
        r.last_row = last;
        return r;
    endfunction

    // One well-formed data set: random symbols, often tied to a shared base
    // symbol so the estimate is far from zero.
    task automatic send_random_set(input int n);
        int unsigned base;
        int unsigned v [4];
        bit          linked;
        linked = $urandom_range(1);
        for (int i = 0; i < n; i++)
        begin
            base = $urandom_range(7);
            for (int j = 0; j < 4; j++)
                v[j] = (linked && $urandom_range(3) != 0) ? base : $urandom_range(7);
            send_row(make_row(v[0], v[1], v[2], v[3], i == n - 1));
        end
    endtask

    initial
    begin
        logic [VC_BITS-1:0] sweep [8];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        row_ch.valid = 1'b0;
        row_ch.data  = '0;
        idle_en      = 1'b1;
        hold_request = 0;
        rows_sent    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset value of var_count (two variables): a tiny set first.
        send_row(make_row(0, 7, 5, 2, 0));
        send_row(make_row(7, 0, 2, 5, 1));

        // Four variables: all-zero and all-seven rows and a mixed last row, then a single-row set.
        set_var_count(3'd4);
        send_row(make_row(0, 0, 0, 0, 0));
        send_row(make_row(7, 7, 7, 7, 0));
        send_row(make_row(5, 2, 7, 0, 1));
        send_row(make_row(3, 4, 1, 6, 1));

        // Perfectly tied variables over all eight symbols: pushes the estimate
        // up to the saturation ceiling.
        for (int s = 0; s < 8; s++)
            send_row(make_row(s, s, s, s, s == 7));

        // Out-of-range counts: seven acts as four, zero acts as one.
        set_var_count(3'd7);
        send_row(make_row(1, 1, 6, 6, 0));
        send_row(make_row(6, 6, 1, 1, 1));
        set_var_count(3'd0);
        send_row(make_row(4, 3, 2, 1, 0));
        send_row(make_row(2, 3, 4, 5, 1));

        // One variable: estimate must be exactly zero.
        set_var_count(3'd1);
        send_row(make_row(6, 1, 0, 7, 0));
        send_row(make_row(1, 6, 7, 0, 1));

        // Random phases through var_count values 0 to 5 and 7.
        sweep = '{3'd2, 3'd4, 3'd1, 3'd3, 3'd7, 3'd0, 3'd5, 3'd4};
        for (int p = 0; p < 8; p++)
        begin
            set_var_count(sweep[p]);
            idle_en = (p != 3);
            if (p == 5)
            begin
                // Hold results off long enough that a second set backs up.
                hold_request = 20000;
                send_random_set(5);
                send_random_set(5);
            end
            while (rows_sent < (p + 1) * RANDOM_ROWS / 8)
                send_random_set($urandom_range(60) + 1);
        end
        idle_en = 1'b1;
        drop_row_valid();

        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("total_correlation_estimator_unit_tb: clean");
        else
            $display("total_correlation_estimator_unit_tb: errors");
        $finish;
    end
endmodule
